[rtl/utf8_to_code_point_decoder_macros.svh]
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Assertion forms used by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODE_POINT_DECODER_MACROS_SVH
`define UTF8_TO_CODE_POINT_DECODER_MACROS_SVH

// plain property, clocked and held off during reset
`define UTF8D_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same-cycle implication
`define UTF8D_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned REM_W  = 2;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CP_W-1:0]   cp_t;
	typedef logic [REM_W-1:0]  rem_t;

	// decoder state carried between beats
	typedef struct packed {
		logic in_seq;
		rem_t rem;
		cp_t  partial;
	} dec_state_t;

	// result of one beat
	typedef struct packed {
		logic emit;
		logic invalid;
		cp_t  code_point;
	} dec_result_t;

endpackage

[rtl/utf8_to_code_point_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// Streams UTF-8 bytes in, gives code points (or an invalid mark) out.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------
//  in      | in_valid/in_ready  | data_byte, end_of_buffer
//  out     | out_valid/out_ready| code_point, invalid
//
// One byte per cycle sustained while the output is not stalled; a beat lands
// in the input register, is decoded combinationally against the held state,
// and any result it yields is registered in the output register that drives
// out_valid, code_point and invalid.
// Reset clears the sequence state and both valid flags.
// A stalled result holds the input register; input stalls once it fills.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  utf8d_pkg::byte_t  data_byte,
	input  logic              end_of_buffer,
	output logic              out_valid,
	input  logic              out_ready,
	output utf8d_pkg::cp_t    code_point,
	output logic              invalid
);
	import utf8d_pkg::*;

	logic        valid_s1;
	byte_t       data_s1;
	logic        eob_s1;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;
	logic        out_valid_q;
	cp_t         code_point_q;
	logic        invalid_q;
	logic        adv;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;

	utf8d_step u_step (
		.data (data_s1),
		.eob  (eob_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res.emit;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res.emit) begin
			code_point_q <= res.code_point;
			invalid_q    <= res.invalid;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = code_point_q;
	assign invalid    = invalid_q;

endmodule

[rtl/utf8d_step.sv]
// ----------------------------------------------------------------------------
// utf8d_step
// Next-state and result logic for one byte of the UTF-8 decoder.
// ----------------------------------------------------------------------------
module utf8d_step (
	input  utf8d_pkg::byte_t       data,
	input  logic                   eob,
	input  utf8d_pkg::dec_state_t  cur,
	output utf8d_pkg::dec_state_t  nxt,
	output utf8d_pkg::dec_result_t res
);
	import utf8d_pkg::*;

	rem_t rem_dec;
	cp_t  cont_bits;
	cp_t  merged;

	assign rem_dec = cur.rem - rem_t'(1);
	assign merged  = cur.partial | cont_bits;

	// place the six payload bits by how many continuation beats remain after this one
	always_comb begin
		case (rem_dec)
			2'd0:    cont_bits = {{(CP_W-6){1'b0}}, data[5:0]};
			2'd1:    cont_bits = {{(CP_W-12){1'b0}}, data[5:0], 6'd0};
			default: cont_bits = {{(CP_W-18){1'b0}}, data[5:0], 12'd0};
		endcase
	end

	always_comb begin
		nxt = '0;
		res = '0;
		if (!data[7]) begin
			// ASCII; an open sequence makes it a truncation
			res.emit       = 1'b1;
			res.invalid    = cur.in_seq;
			res.code_point = cur.in_seq ? '0 : {{(CP_W-7){1'b0}}, data[6:0]};
		end else if (data[6]) begin
			// lead byte; abandons any open sequence without reopening
			if (!cur.in_seq) begin
				if (!data[5]) begin
					nxt.in_seq  = 1'b1;
					nxt.rem     = 2'd1;
					nxt.partial = {{(CP_W-11){1'b0}}, data[4:0], 6'd0};
				end else if (!data[4]) begin
					nxt.in_seq  = 1'b1;
					nxt.rem     = 2'd2;
					nxt.partial = {{(CP_W-16){1'b0}}, data[3:0], 12'd0};
				end else if (!data[3]) begin
					nxt.in_seq  = 1'b1;
					nxt.rem     = 2'd3;
					nxt.partial = {data[2:0], 18'd0};
				end
			end
			if (eob) begin
				nxt         = '0;
				res.emit    = 1'b1;
				res.invalid = 1'b1;
			end
		end else begin
			if (cur.in_seq && (cur.rem != '0)) begin
				if (rem_dec == '0) begin
					res.emit       = 1'b1;
					res.code_point = merged;
				end else if (eob) begin
					res.emit    = 1'b1;
					res.invalid = 1'b1;
				end else begin
					nxt.in_seq  = 1'b1;
					nxt.rem     = rem_dec;
					nxt.partial = merged;
				end
			end else if (eob) begin
				// stray continuation at end of buffer
				res.emit    = 1'b1;
				res.invalid = 1'b1;
			end
		end
	end

endmodule

[rtl/utf8d_checker.sv]
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_code_point_decoder_macros.svh"

module utf8d_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input utf8d_pkg::cp_t code_point,
	input logic           invalid
);
	import utf8d_pkg::*;

	// a held result keeps its beat
	`UTF8D_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(invalid), "result changed while stalled")

	// an invalid mark never carries a code point
	`UTF8D_ASSERT_IMPLY(a_invalid_zero, clk, arst_n, out_valid && invalid, code_point == '0, "invalid result with nonzero code point")

	// a fresh result must trace back to an input beat
	`UTF8D_ASSERT_IMPLY(a_result_latency, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a matching input beat")

endmodule

bind utf8_to_code_point_decoder utf8d_checker u_utf8d_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.code_point (code_point),
	.invalid    (invalid)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - UTF-8 to code point decoder testbench
// Streams directed and random UTF-8 bytes into the decoder with random idle
// and stall bursts, predicts each decoded character or invalid mark, and
// checks every output beat in order against the prediction.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import utf8d_pkg::*;

	localparam int unsigned TOTAL_BEATS    = 1800;
	localparam int unsigned QUIET_FROM     = 1600;
	localparam int unsigned PAUSE_AT       = 900;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned MAX_REPORTS    = 10;

	typedef struct packed {
		logic invalid;
		cp_t  code_point;
	} char_result_t;

	// decoder prediction plus in-order store of predicted characters
	class utf8_scoreboard;
		char_result_t expected_chars[$];
		logic         seq_open;
		rem_t         cont_left;
		cp_t          partial_cp;
		int unsigned  fail_count;

		function new();
			clear_seq();
			fail_count = 0;
		endfunction

		function void clear_seq();
			seq_open   = 1'b0;
			cont_left  = '0;
			partial_cp = '0;
		endfunction

		function void push_char(cp_t cp, logic bad);
			char_result_t r;
			r.invalid    = bad;
			r.code_point = bad ? cp_t'(0) : cp;
			expected_chars.push_back(r);
			clear_seq();
		endfunction

		function void note_byte(byte_t b, logic eob);
			int unsigned ones;
			ones = 0;
			if (!b[7]) begin
				// ASCII ends any open sequence as truncated
				push_char(cp_t'(b), seq_open);
			end else if (b[7:6] == 2'b11) begin
				if (seq_open) begin
					clear_seq();
				end else begin
					while (ones < 8 && b[7 - ones])
						ones++;
					if (ones > 4) begin
						clear_seq();
					end else begin
						seq_open   = 1'b1;
						cont_left  = rem_t'(ones - 1);
						partial_cp = cp_t'(b & (8'h7F >> ones));
						partial_cp = partial_cp << (6 * (ones - 1));
					end
				end
				if (eob)
					push_char('0, 1'b1);
			end else if (!seq_open || cont_left == 0) begin
				// stray continuation
				clear_seq();
				if (eob)
					push_char('0, 1'b1);
			end else begin
				cont_left  = cont_left - 1'b1;
				partial_cp = partial_cp | (cp_t'(b[5:0]) << (6 * int'(cont_left)));
				if (cont_left == 0)
					push_char(partial_cp, 1'b0);
				else if (eob)
					push_char('0, 1'b1);
			end
		endfunction

		function void log_mismatch(string what, char_result_t exp, cp_t cp, logic inv);
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s: expected cp=%06h invalid=%0b, got cp=%06h invalid=%0b",
					$realtime, what, exp.code_point, exp.invalid, cp, inv);
		endfunction

		function void check_char(cp_t cp, logic inv);
			char_result_t exp;
			if (expected_chars.size() == 0) begin
				exp = '0;
				log_mismatch("unexpected beat", exp, cp, inv);
			end else begin
				exp = expected_chars.pop_front();
				if (exp.code_point !== cp || exp.invalid !== inv)
					log_mismatch("mismatch", exp, cp, inv);
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	byte_t data_byte;
	logic  end_of_buffer;
	logic  out_valid;
	logic  out_ready;
	cp_t   code_point;
	logic  invalid;

	utf8_scoreboard sb;
	int unsigned    beats_sent;
	int unsigned    stall_cycles;
	logic           quiet_tail;

	utf8_to_code_point_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.code_point    (code_point),
		.invalid       (invalid)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// called at a falling edge; returns at a falling edge after the beat, after any idle burst
	task automatic send_beat(byte_t b, logic eob);
		in_valid      <= 1'b1;
		data_byte     <= b;
		end_of_buffer <= eob;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b, eob);
		beats_sent++;
		@(negedge clk);
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	// lead byte for a len-byte character, then keep-1 continuations
	task automatic send_seq(int unsigned len, int unsigned keep);
		byte_t b;
		for (int i = 0; i < keep; i++) begin
			if (i != 0)
				b = {2'b10, 6'($urandom)};
			else if (len == 1)
				b = {1'b0, 7'($urandom)};
			else if (len == 2)
				b = {3'b110, 5'($urandom)};
			else if (len == 3)
				b = {4'b1110, 4'($urandom)};
			else
				b = {5'b11110, 3'($urandom)};
			send_beat(b, $urandom_range(0, 15) == 0);
		end
	endtask

	// output side: ready with random stall bursts, none in the tail
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			if (!quiet_tail && $urandom_range(0, 1) == 1) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_char(code_point, invalid);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int unsigned pick;
		int unsigned len;
		logic        paused;
		sb            = new();
		beats_sent    = 0;
		stall_cycles  = 0;
		quiet_tail    = 1'b0;
		paused        = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		data_byte     = '0;
		end_of_buffer = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ASCII extremes, one with end of buffer
		send_beat(8'h00, 1'b0);
		send_beat(8'h7F, 1'b1);
		// two, three and four byte characters, incl. the largest code point
		send_beat(8'hC2, 1'b0);
		send_beat(8'hA9, 1'b0);
		send_beat(8'hE2, 1'b0);
		send_beat(8'h82, 1'b0);
		send_beat(8'hAC, 1'b0);
		send_beat(8'hF7, 1'b0);
		send_beat(8'hBF, 1'b0);
		send_beat(8'hBF, 1'b0);
		send_beat(8'hBF, 1'b0);
		send_beat(8'hDF, 1'b0);
		send_beat(8'hBF, 1'b1);
		// bad lead bytes, silent and with end of buffer
		send_beat(8'hF8, 1'b0);
		send_beat(8'hFF, 1'b1);
		// stray continuations
		send_beat(8'h80, 1'b0);
		send_beat(8'hBF, 1'b1);
		// lead inside an open sequence drops both
		send_beat(8'hC3, 1'b0);
		send_beat(8'hE1, 1'b0);
		send_beat(8'h41, 1'b0);
		// ASCII cuts a sequence short
		send_beat(8'hE1, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'h41, 1'b0);
		// end of buffer on a lead and on a middle continuation
		send_beat(8'hC0, 1'b1);
		send_beat(8'hF0, 1'b0);
		send_beat(8'h90, 1'b1);

		while (beats_sent < TOTAL_BEATS) begin
			if (!paused && beats_sent >= PAUSE_AT) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (sb.expected_chars.size() != 0);
				paused = 1'b1;
			end
			quiet_tail = (beats_sent >= QUIET_FROM);
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				len = $urandom_range(1, 4);
				send_seq(len, len);
			end else if (pick == 7) begin
				len = $urandom_range(2, 4);
				send_seq(len, $urandom_range(1, len - 1));
			end else begin
				send_beat(8'($urandom), $urandom_range(0, 3) == 0);
			end
		end

		in_valid <= 1'b0;
		while (sb.expected_chars.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
